// ===== sv/pgsc_pkg.sv =====
// Package for the pressure gate stepper controller: field widths, register
// indexes, event codes, reset values and the state and configuration structs.
// No dependencies.
package pgsc_pkg;

    localparam int PressW  = 8;
    localparam int PeriodW = 16;
    localparam int StepsW  = 12;
    localparam int CoilW   = 4;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 16;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CAR_THRESHOLD   = 3'd0,
        REG_HOLD_MARGIN     = 3'd1,
        REG_LIGHT_THRESHOLD = 3'd2,
        REG_OPEN_PERIOD     = 3'd3,
        REG_CLOSE_PERIOD    = 3'd4,
        REG_TRAVEL_STEPS    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        GATE_EVT_NONE    = 2'd0,
        GATE_EVT_OPENING = 2'd1,
        GATE_EVT_CLOSING = 2'd2
    } gate_evt_t;

    typedef enum logic [1:0] {
        LOCK_EVT_NONE     = 2'd0,
        LOCK_EVT_LOCKED   = 2'd1,
        LOCK_EVT_UNLOCKED = 2'd2
    } lock_evt_t;

    localparam logic [PressW-1:0]  CAR_THRESHOLD_RST   = 8'd151;
    localparam logic [PressW-1:0]  HOLD_MARGIN_RST     = 8'd20;
    localparam logic [PressW-1:0]  LIGHT_THRESHOLD_RST = 8'd45;
    localparam logic [PeriodW-1:0] OPEN_PERIOD_RST     = 16'd6056;
    localparam logic [PeriodW-1:0] CLOSE_PERIOD_RST    = 16'd2422;
    localparam logic [StepsW-1:0]  TRAVEL_STEPS_RST    = 12'd2064;
    localparam logic [CoilW-1:0]   PHASE_RST           = 4'b0011;

    typedef struct packed {
        logic [PressW-1:0]  car_threshold;
        logic [PressW-1:0]  hold_margin;
        logic [PressW-1:0]  light_threshold;
        logic [PeriodW-1:0] open_period;
        logic [PeriodW-1:0] close_period;
        logic [StepsW-1:0]  travel_steps;
    } pgsc_cfg_t;

    typedef struct packed {
        logic               locked;
        logic               position_open;
        logic               heading_open;
        logic               travelling;
        logic               holding;
        logic               driven;
        logic [PeriodW-1:0] active_period;
        logic [CoilW-1:0]   phase_pattern;
        logic [StepsW-1:0]  steps_done;
        logic [PeriodW-1:0] tick_count;
    } pgsc_state_t;

    localparam pgsc_state_t STATE_RST = '{
        locked:        1'b0,
        position_open: 1'b0,
        heading_open:  1'b1,
        travelling:    1'b0,
        holding:       1'b0,
        driven:        1'b0,
        active_period: '0,
        phase_pattern: PHASE_RST,
        steps_done:    '0,
        tick_count:    '0
    };

    typedef struct packed {
        logic [CoilW-1:0] coils;
        logic             alert_lights;
        logic             lock_lamp;
        logic             gate_open;
        logic             in_motion;
        gate_evt_t        gate_event;
        lock_evt_t        lock_event;
    } pgsc_result_t;

endpackage

// ===== sv/pgsc_tick_if.sv =====
// Tick input channel: valid/ready plus the pressure sample and lock-key strobe.
// Depends on pgsc_pkg.
interface pgsc_tick_if;
    logic                      valid;
    logic                      ready;
    logic [pgsc_pkg::PressW-1:0] pressure;
    logic                      lock_key;

    modport source (output valid, output pressure, output lock_key, input ready);
    modport sink   (input valid, input pressure, input lock_key, output ready);
endinterface

// ===== sv/pgsc_result_if.sv =====
// Result output channel: valid/ready plus the coil drive and status fields.
// Depends on pgsc_pkg.
interface pgsc_result_if;
    logic                       valid;
    logic                       ready;
    logic [pgsc_pkg::CoilW-1:0] coils;
    logic                       alert_lights;
    logic                       lock_lamp;
    logic                       gate_open;
    logic                       in_motion;
    logic [1:0]                 gate_event;
    logic [1:0]                 lock_event;

    modport source (output valid, output coils, output alert_lights, output lock_lamp,
                    output gate_open, output in_motion, output gate_event,
                    output lock_event, input ready);
    modport sink   (input valid, input coils, input alert_lights, input lock_lamp,
                    input gate_open, input in_motion, input gate_event,
                    input lock_event, output ready);
endinterface

// ===== sv/pgsc_cfg_if.sv =====
// Configuration write channel: valid/ready plus register index and write data.
// Depends on pgsc_pkg.
interface pgsc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pgsc_pkg::CfgIdxW-1:0]  index;
    logic [pgsc_pkg::CfgDataW-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pgsc_cfg_regs.sv =====
// Configuration register file, written through the cfg channel.
// Depends on pgsc_pkg and pgsc_cfg_if.
module pgsc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    pgsc_cfg_if.sink            cfg,
    output pgsc_pkg::pgsc_cfg_t regs
);
    import pgsc_pkg::*;

    pgsc_cfg_t regs_reg;
    logic      wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.car_threshold   <= CAR_THRESHOLD_RST;
            regs_reg.hold_margin     <= HOLD_MARGIN_RST;
            regs_reg.light_threshold <= LIGHT_THRESHOLD_RST;
            regs_reg.open_period     <= OPEN_PERIOD_RST;
            regs_reg.close_period    <= CLOSE_PERIOD_RST;
            regs_reg.travel_steps    <= TRAVEL_STEPS_RST;
        end
        else if (wr)
        begin
            // indexes past the list are ignored
            unique case (cfg_reg_t'(cfg.index))
                REG_CAR_THRESHOLD:   regs_reg.car_threshold   <= cfg.data[PressW-1:0];
                REG_HOLD_MARGIN:     regs_reg.hold_margin     <= cfg.data[PressW-1:0];
                REG_LIGHT_THRESHOLD: regs_reg.light_threshold <= cfg.data[PressW-1:0];
                REG_OPEN_PERIOD:     regs_reg.open_period     <= cfg.data[PeriodW-1:0];
                REG_CLOSE_PERIOD:    regs_reg.close_period    <= cfg.data[PeriodW-1:0];
                REG_TRAVEL_STEPS:    regs_reg.travel_steps    <= cfg.data[StepsW-1:0];
                default:             ;
            endcase
        end
    end

endmodule

// ===== sv/pgsc_step_logic.sv =====
// Combinational next-state and result logic for one tick.
// Depends on pgsc_pkg.
module pgsc_step_logic (
    input  pgsc_pkg::pgsc_cfg_t             regs,
    input  pgsc_pkg::pgsc_state_t           cur,
    input  logic [pgsc_pkg::PressW-1:0]     pressure,
    input  logic                            lock_key,
    output pgsc_pkg::pgsc_state_t           nxt,
    output pgsc_pkg::pgsc_result_t          res
);
    import pgsc_pkg::*;

    logic              locked_k;
    logic              do_step;
    logic              reverse;
    logic              heading_s;
    logic [StepsW-1:0] steps_base;
    logic [StepsW:0]   steps_inc;
    logic              travel_end;
    logic              hold_release;
    logic [PressW:0]   press_plus_margin;
    pgsc_state_t       s;
    gate_evt_t         gate_evt;
    lock_evt_t         lock_evt;

    // lock key toggles first
    assign locked_k = cur.locked ^ lock_key;

    // step when the tick counter has reached the period
    assign do_step    = cur.travelling && (cur.tick_count >= cur.active_period);
    // locking during an opening turns the travel around at this step
    assign reverse    = locked_k && cur.heading_open;
    assign heading_s  = cur.heading_open && !reverse;
    assign steps_base = reverse ? (regs.travel_steps - cur.steps_done) : cur.steps_done;
    assign steps_inc  = {1'b0, steps_base} + {{StepsW{1'b0}}, 1'b1};
    assign travel_end = steps_inc >= {1'b0, regs.travel_steps};

    // pressure < car - margin, without a negative level
    assign press_plus_margin = {1'b0, pressure} + {1'b0, regs.hold_margin};

    always_comb
    begin
        s        = cur;
        s.locked = locked_k;
        gate_evt = GATE_EVT_NONE;
        lock_evt = LOCK_EVT_NONE;
        hold_release = 1'b0;

        if (lock_key)
        begin
            lock_evt = locked_k ? LOCK_EVT_LOCKED : LOCK_EVT_UNLOCKED;
        end

        if (cur.travelling)
        begin
            if (do_step)
            begin
                s.tick_count   = '0;
                s.heading_open = heading_s;
                if (reverse)
                begin
                    gate_evt = GATE_EVT_CLOSING;
                end
                if (heading_s)
                begin
                    s.phase_pattern = {cur.phase_pattern[CoilW-2:0], cur.phase_pattern[CoilW-1]};
                end
                else
                begin
                    s.phase_pattern = {cur.phase_pattern[0], cur.phase_pattern[CoilW-1:1]};
                end
                s.driven = 1'b1;
                if (travel_end)
                begin
                    s.travelling    = 1'b0;
                    s.steps_done    = '0;
                    s.position_open = heading_s;
                end
                else
                begin
                    s.steps_done = steps_inc[StepsW-1:0];
                end
            end
            else
            begin
                s.tick_count = cur.tick_count + 1'b1;
            end
        end

        if (cur.holding)
        begin
            hold_release = locked_k || (press_plus_margin < {1'b0, regs.car_threshold});
            if (hold_release)
            begin
                s.holding = 1'b0;
            end
        end

        if (!s.holding && !s.travelling)
        begin
            if ((pressure >= regs.car_threshold) && !locked_k)
            begin
                if (!s.position_open)
                begin
                    s.heading_open  = 1'b1;
                    s.active_period = regs.open_period;
                    s.travelling    = 1'b1;
                    s.tick_count    = '0;
                    s.holding       = 1'b1;
                    gate_evt        = GATE_EVT_OPENING;
                end
            end
            else if (s.position_open)
            begin
                s.heading_open  = 1'b0;
                s.active_period = regs.close_period;
                s.travelling    = 1'b1;
                s.tick_count    = '0;
                gate_evt        = GATE_EVT_CLOSING;
            end
        end

        nxt = s;

        res.coils        = s.driven ? s.phase_pattern : '0;
        res.alert_lights = pressure > regs.light_threshold;
        res.lock_lamp    = s.locked;
        res.gate_open    = s.position_open;
        res.in_motion    = s.travelling;
        res.gate_event   = gate_evt;
        res.lock_event   = lock_evt;
    end

endmodule

// ===== sv/pressure_gate_stepper_controller.sv =====
// Pressure gate stepper controller, top level.
// A tick is held in the input register, and its result then loads into the result
// register; throughput is one tick per cycle while results are taken downstream,
// set by the single combinational state update between the two registers. A held
// result stalls the input only once the input register is also full.
// Reset (rst_n, async, active low) restores default configuration, unlocked and
// closed gate, coil pattern 0011 undriven, and empties both pipeline registers.
module pressure_gate_stepper_controller (
    input  logic        clk,
    input  logic        rst_n,
    pgsc_tick_if.sink   tick,
    pgsc_result_if.source result,
    pgsc_cfg_if.sink    cfg
);
    import pgsc_pkg::*;

    // Configuration registers
    pgsc_cfg_t regs;

    pgsc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    // Input register stage: holds one accepted tick
    logic              in_valid_reg;
    logic [PressW-1:0] in_pressure_reg;
    logic              in_lock_key_reg;

    // Controller state, updated when the input stage hands its tick on
    pgsc_state_t  state_reg;
    pgsc_state_t  state_next;
    pgsc_result_t res_next;

    // Result register stage
    logic         res_valid_reg;
    pgsc_result_t res_reg;

    logic advance;   // result register can load this cycle
    logic tick_xfer;

    pgsc_step_logic u_step_logic (
        .regs     (regs),
        .cur      (state_reg),
        .pressure (in_pressure_reg),
        .lock_key (in_lock_key_reg),
        .nxt      (state_next),
        .res      (res_next)
    );

    // The result register frees up when it is empty or its transfer completes;
    // the input register then empties into it, so a new tick can enter the
    // same cycle. An empty input register also takes a tick while a finished
    // result is still waiting downstream.
    assign advance    = !res_valid_reg || result.ready;
    assign tick.ready = !in_valid_reg || advance;
    assign tick_xfer  = tick.valid && tick.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= STATE_RST;
        end
        else
        begin
            if (tick.ready)
            begin
                in_valid_reg <= tick.valid;
            end
            if (advance)
            begin
                res_valid_reg <= in_valid_reg;
                if (in_valid_reg)
                begin
                    state_reg <= state_next;
                end
            end
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_xfer)
        begin
            in_pressure_reg <= tick.pressure;
            in_lock_key_reg <= tick.lock_key;
        end
        if (advance && in_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.coils        = res_reg.coils;
    assign result.alert_lights = res_reg.alert_lights;
    assign result.lock_lamp    = res_reg.lock_lamp;
    assign result.gate_open    = res_reg.gate_open;
    assign result.in_motion    = res_reg.in_motion;
    assign result.gate_event   = res_reg.gate_event;
    assign result.lock_event   = res_reg.lock_event;

endmodule

// ===== test/testbench.sv =====
// Testbench for the pressure gate stepper controller: drives timer ticks and register
// writes, predicts every status result and compares it field by field.
// Depends on pgsc_pkg, the tick, result and cfg channel interfaces and the controller RTL.
module testbench;
    import pgsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 175;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_pattern_t;
    typedef enum {SCENE_CAR, SCENE_CLEAR, SCENE_HOVER, SCENE_NOISE} scene_t;

    // Shadow of the gate controller: its own copy of the registers and state, a queue
    // of status words still owed by the block, and a few counters for the summary.
    class gate_tick_scoreboard;
        pgsc_cfg_t    settings;
        pgsc_state_t  gate;
        pgsc_result_t expected_status[$];
        int unsigned  failures, ticks_seen, openings, closings, reversals, lock_flips;

        function new();
            settings.car_threshold   = CAR_THRESHOLD_RST;
            settings.hold_margin     = HOLD_MARGIN_RST;
            settings.light_threshold = LIGHT_THRESHOLD_RST;
            settings.open_period     = OPEN_PERIOD_RST;
            settings.close_period    = CLOSE_PERIOD_RST;
            settings.travel_steps    = TRAVEL_STEPS_RST;
            gate = STATE_RST;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CfgDataW-1:0] value);
            case (idx)
                REG_CAR_THRESHOLD:   settings.car_threshold   = value[PressW-1:0];
                REG_HOLD_MARGIN:     settings.hold_margin     = value[PressW-1:0];
                REG_LIGHT_THRESHOLD: settings.light_threshold = value[PressW-1:0];
                REG_OPEN_PERIOD:     settings.open_period     = value[PeriodW-1:0];
                REG_CLOSE_PERIOD:    settings.close_period    = value[PeriodW-1:0];
                REG_TRAVEL_STEPS:    settings.travel_steps    = value[StepsW-1:0];
                default: ;
            endcase
        endfunction

        // One accepted tick: lock key, then travel step, then hold release, then decision.
        function void predict_tick(logic [PressW-1:0] level, logic key);
            pgsc_result_t status;
            int next_count;
            int hold_level;
            int sample;
            status.gate_event = GATE_EVT_NONE;
            status.lock_event = LOCK_EVT_NONE;
            ticks_seen++;

            if (key) begin
                gate.locked = !gate.locked;
                status.lock_event = gate.locked ? LOCK_EVT_LOCKED : LOCK_EVT_UNLOCKED;
                lock_flips++;
            end

            if (gate.travelling) begin
                if (gate.tick_count >= gate.active_period) begin
                    gate.tick_count = '0;
                    // locked while opening: turn around, keep the period
                    if (gate.locked && gate.heading_open) begin
                        gate.heading_open = 1'b0;
                        gate.steps_done = settings.travel_steps - gate.steps_done;
                        status.gate_event = GATE_EVT_CLOSING;
                        reversals++;
                    end
                    next_count = gate.steps_done + 1;
                    if (gate.heading_open)
                        gate.phase_pattern = {gate.phase_pattern[2:0], gate.phase_pattern[3]};
                    else
                        gate.phase_pattern = {gate.phase_pattern[0], gate.phase_pattern[3:1]};
                    gate.driven = 1'b1;
                    // >= so that a zero or shrunken travel ends at this step
                    if (next_count >= settings.travel_steps) begin
                        gate.travelling    = 1'b0;
                        gate.steps_done    = '0;
                        gate.position_open = gate.heading_open;
                    end else begin
                        gate.steps_done = next_count[StepsW-1:0];
                    end
                end else begin
                    gate.tick_count = gate.tick_count + 1'b1;
                end
            end

            // release level may go negative: then only locking ends the hold
            if (gate.holding) begin
                hold_level = settings.car_threshold;
                hold_level = hold_level - settings.hold_margin;
                sample = level;
                if (gate.locked || sample < hold_level)
                    gate.holding = 1'b0;
            end

            if (!gate.holding && !gate.travelling) begin
                if (level >= settings.car_threshold && !gate.locked) begin
                    if (!gate.position_open) begin
                        gate.heading_open  = 1'b1;
                        gate.active_period = settings.open_period;
                        gate.travelling    = 1'b1;
                        gate.tick_count    = '0;
                        gate.holding       = 1'b1;
                        status.gate_event  = GATE_EVT_OPENING;
                        openings++;
                    end
                end else if (gate.position_open) begin
                    gate.heading_open  = 1'b0;
                    gate.active_period = settings.close_period;
                    gate.travelling    = 1'b1;
                    gate.tick_count    = '0;
                    status.gate_event  = GATE_EVT_CLOSING;
                    closings++;
                end
            end

            status.coils        = gate.driven ? gate.phase_pattern : '0;
            status.alert_lights = level > settings.light_threshold;
            status.lock_lamp    = gate.locked;
            status.gate_open    = gate.position_open;
            status.in_motion    = gate.travelling;
            expected_status.push_back(status);
        endfunction

        function void compare_field(string field, logic [3:0] want, logic [3:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", field, want, got);
                failures++;
            end
        endfunction

        function void check_status(pgsc_result_t got);
            pgsc_result_t want;
            if (expected_status.size() == 0) begin
                $error("status transfer with no tick outstanding");
                failures++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("coils",        want.coils,        got.coils);
            compare_field("alert_lights", want.alert_lights, got.alert_lights);
            compare_field("lock_lamp",    want.lock_lamp,    got.lock_lamp);
            compare_field("gate_open",    want.gate_open,    got.gate_open);
            compare_field("in_motion",    want.in_motion,    got.in_motion);
            compare_field("gate_event",   want.gate_event,   got.gate_event);
            compare_field("lock_event",   want.lock_event,   got.lock_event);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pgsc_tick_if   tick_ch();
    pgsc_result_if result_ch();
    pgsc_cfg_if    cfg_ch();

    pressure_gate_stepper_controller dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    gate_tick_scoreboard sb = new();
    idle_pattern_t idle_mode = IDLE_NONE;
    int unsigned   quiet_cycles = 0;
    int unsigned   setting_loads = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit sender_waits();
        case (idle_mode)
            IDLE_SENDER: return $urandom_range(0, 99) < 88;
            IDLE_BOTH:   return $urandom_range(0, 99) < 26;
            default:     return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mode)
            IDLE_RECEIVER: return $urandom_range(0, 99) < 88;
            IDLE_BOTH:     return $urandom_range(0, 99) < 26;
            default:       return 1'b0;
        endcase
    endfunction

    // receiver side: ready moves on the falling edge only
    always @(negedge clk)
    begin
        result_ch.ready <= !receiver_stalls();
    end

    // Everything is sampled on the rising edge. A tick transfer feeds the predictor,
    // a status transfer is checked against the oldest prediction. The watchdog ends
    // the run once no channel has moved a transfer for too long.
    always @(posedge clk)
    begin : bus_monitor
        pgsc_result_t seen;
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (tick_ch.valid && tick_ch.ready) begin
                sb.predict_tick(tick_ch.pressure, tick_ch.lock_key);
                moved = 1'b1;
            end
            if (result_ch.valid && result_ch.ready) begin
                seen.coils        = result_ch.coils;
                seen.alert_lights = result_ch.alert_lights;
                seen.lock_lamp    = result_ch.lock_lamp;
                seen.gate_open    = result_ch.gate_open;
                seen.in_motion    = result_ch.in_motion;
                seen.gate_event   = gate_evt_t'(result_ch.gate_event);
                seen.lock_event   = lock_evt_t'(result_ch.lock_event);
                sb.check_status(seen);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready)
                moved = 1'b1;
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer with
    // valid still high; valid drops between back-to-back ticks only while the sender waits.
    task automatic send_tick(input logic [PressW-1:0] level, input logic key);
        while (sender_waits()) begin
            tick_ch.valid <= 1'b0;
            @(negedge clk);
        end
        tick_ch.valid    <= 1'b1;
        tick_ch.pressure <= level;
        tick_ch.lock_key <= key;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop sending and wait until every owed status word has come back
    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (sb.expected_status.size() != 0)
            @(negedge clk);
    endtask

    function automatic pgsc_cfg_t make_settings(int car, int margin, int light,
                                                int open_p, int close_p, int steps);
        pgsc_cfg_t c;
        c.car_threshold   = car[PressW-1:0];
        c.hold_margin     = margin[PressW-1:0];
        c.light_threshold = light[PressW-1:0];
        c.open_period     = open_p[PeriodW-1:0];
        c.close_period    = close_p[PeriodW-1:0];
        c.travel_steps    = steps[StepsW-1:0];
        return c;
    endfunction

    // Writes all six registers back to back; only called with the pipeline empty.
    task automatic load_settings(input pgsc_cfg_t c);
        cfg_reg_t order [6];
        logic [CfgDataW-1:0] value;
        order = '{REG_CAR_THRESHOLD, REG_HOLD_MARGIN, REG_LIGHT_THRESHOLD,
                  REG_OPEN_PERIOD, REG_CLOSE_PERIOD, REG_TRAVEL_STEPS};
        foreach (order[i]) begin
            case (order[i])
                REG_CAR_THRESHOLD:   value = CfgDataW'(c.car_threshold);
                REG_HOLD_MARGIN:     value = CfgDataW'(c.hold_margin);
                REG_LIGHT_THRESHOLD: value = CfgDataW'(c.light_threshold);
                REG_OPEN_PERIOD:     value = CfgDataW'(c.open_period);
                REG_CLOSE_PERIOD:    value = CfgDataW'(c.close_period);
                default:             value = CfgDataW'(c.travel_steps);
            endcase
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= order[i];
            cfg_ch.data  <= value;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            sb.write_reg(order[i], value);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
        setting_loads++;
    endtask

    // Short periods and travels keep each gate cycle to a few dozen ticks; the
    // thresholds sometimes sit at their ends, and travel_steps is sometimes zero.
    // A write of a smaller travel_steps while the gate moves shrinks that travel.
    function automatic pgsc_cfg_t random_settings();
        int car, margin, steps;
        case ($urandom_range(0, 9))
            0:       car = 0;
            1:       car = 255;
            default: car = $urandom_range(60, 200);
        endcase
        case ($urandom_range(0, 9))
            0:       margin = 0;
            1:       margin = 255;
            default: margin = $urandom_range(0, 60);
        endcase
        case ($urandom_range(0, 9))
            0:       steps = 0;
            1:       steps = $urandom_range(12, 24);
            default: steps = $urandom_range(1, 8);
        endcase
        return make_settings(car, margin, $urandom_range(0, 255),
                             $urandom_range(0, 3), $urandom_range(0, 3), steps);
    endfunction

    // pressure for a scene, relative to the thresholds now in force
    function automatic logic [PressW-1:0] scene_pressure(scene_t scene);
        int car, release_level;
        car = sb.settings.car_threshold;
        release_level = car - int'(sb.settings.hold_margin);
        case (scene)
            SCENE_CAR:
                return PressW'($urandom_range(car, 255));
            SCENE_CLEAR:
                return (release_level > 0) ? PressW'($urandom_range(0, release_level - 1))
                                           : PressW'($urandom_range(0, 255));
            SCENE_HOVER:
                return PressW'($urandom_range((release_level > 0) ? release_level : 0, car));
            default:
                return PressW'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly car arrivals and departures in runs, so gates open, hold, release and
    // close; some noise with frequent lock keys to catch reversals and locked cars.
    task automatic run_phase(input idle_pattern_t pattern, input int count,
                             input bit pause_midway);
        scene_t scene;
        int run_left;
        int roll;
        logic key;
        idle_mode = pattern;
        run_left = 0;
        scene = SCENE_NOISE;
        for (int n = 0; n < count; n++) begin
            if (run_left == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 35)      scene = SCENE_CAR;
                else if (roll < 65) scene = SCENE_CLEAR;
                else if (roll < 80) scene = SCENE_HOVER;
                else                scene = SCENE_NOISE;
                run_left = $urandom_range(1, 30);
            end
            if (pause_midway && n == count / 2)
                drain();
            if (scene == SCENE_NOISE)
                key = ($urandom_range(0, 2) == 0);
            else
                key = ($urandom_range(0, 24) == 0);
            send_tick(scene_pressure(scene), key);
            run_left--;
        end
    endtask

    initial
    begin
        idle_pattern_t schedule [RANDOM_PHASES];
        schedule = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                     IDLE_BOTH, IDLE_RECEIVER, IDLE_SENDER, IDLE_NONE};
        rst_n            = 1'b0;
        tick_ch.valid    = 1'b0;
        tick_ch.pressure = '0;
        tick_ch.lock_key = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = REG_CAR_THRESHOLD;
        cfg_ch.data      = '0;
        result_ch.ready  = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default thresholds, fast travel: car arrives, gate opens in two steps,
        // hold keeps it open until pressure drops below the release level, then it
        // closes. A locked car is refused, and locking during an opening reverses it.
        load_settings(make_settings(151, 20, 45, 0, 1, 2));
        send_tick(8'd0, 1'b0);   send_tick(8'd255, 1'b0);
        send_tick(8'd255, 1'b0); send_tick(8'd200, 1'b0);
        send_tick(8'd140, 1'b0); send_tick(8'd130, 1'b0);
        send_tick(8'd0, 1'b0);   send_tick(8'd0, 1'b0);
        send_tick(8'd0, 1'b0);   send_tick(8'd255, 1'b1);
        send_tick(8'd255, 1'b1); send_tick(8'd255, 1'b1);
        send_tick(8'd255, 1'b0); send_tick(8'd46, 1'b0);

        // Zero period and zero travel, threshold below the margin: the hold
        // never releases on pressure, only when the gate locks.
        drain();
        load_settings(make_settings(0, 255, 0, 0, 0, 0));
        send_tick(8'd0, 1'b0);   send_tick(8'd255, 1'b0);
        send_tick(8'd1, 1'b0);   send_tick(8'd0, 1'b1);
        send_tick(8'd0, 1'b1);   send_tick(8'd128, 1'b0);
        // leave the gate locked, closed and at rest before the long periods go in
        while (sb.gate.travelling || sb.gate.position_open || !sb.gate.locked)
            send_tick(8'd0, !sb.gate.locked);

        // Register ceilings; no travel starts here since a car never counts while
        // locked and nothing below 255 counts as a car.
        drain();
        load_settings(make_settings(255, 0, 255, 65535, 65535, 4095));
        send_tick(8'd254, 1'b0); send_tick(8'd255, 1'b0);
        send_tick(8'd0, 1'b1);   send_tick(8'd128, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            load_settings(random_settings());
            run_phase(schedule[phase], PHASE_TICKS, phase == 1 || phase == 6);
        end

        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d ticks under %0d register settings, four idle patterns",
                 sb.ticks_seen, setting_loads);
        $display("gate opened %0d, closed %0d, reversed %0d times; lock toggled %0d times",
                 sb.openings, sb.closings, sb.reversals, sb.lock_flips);
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
